// ===== design/base64_percent_payload_decoder_top_macros.svh =====
// Assertion macros for the base64 / percent payload decoder.
// Macros expect signals clk and rst_n in the scope where they are used.
// Under SYNTHESIS every macro expands to nothing.
`ifndef BASE64_PERCENT_PAYLOAD_DECODER_TOP_MACROS_SVH
`define BASE64_PERCENT_PAYLOAD_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset
`define BPD_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("decoder check failed");
// Consequent holds in the cycle after the antecedent
`define BPD_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder sequence check failed");
`else
`define BPD_CHECK(label, cond)
`define BPD_CHECK_NEXT(label, ante, cons)
`endif
`endif

// ===== design/bpd_pkg.sv =====
// Package for the base64 / percent payload decoder.
// Holds transaction types, codes and character classification functions.
// No dependencies.
package bpd_pkg;

    // Transaction payloads
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_payload;
    } bpd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       out_last;
    } bpd_out_t;

    // Status codes
    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECODE_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OUTPUT  = 1'd1;
    localparam int unsigned CFG_DATA_W = 24;

    // Decode modes
    localparam logic MODE_PERCENT = 1'b0;
    localparam logic MODE_BASE64  = 1'b1;

    // Counter width and saturation value
    localparam int unsigned COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFF_FFFF;

    // Special characters
    localparam logic [7:0] CH_PAD     = 8'h3D;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Escape digit counts
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_LOW  = 2'd1;
    localparam logic [1:0] ESC_HIGH = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } nibble_t;

    // Map a base64 alphabet character to its 6-bit value
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            r.val = 6'd62;
        end
        else if (c == 8'h2F) begin
            r.val = 6'd63;
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Map a hex digit (either case) to its 4-bit value
    function automatic nibble_t nibble_of(input logic [7:0] c);
        nibble_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h41 + 8'd10);
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Whitespace: tab through carriage return, and space
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ===== design/base64_percent_payload_decoder_top.sv =====
// A decoded byte or end status is loaded into the output register in the cycle after
// its input transaction is accepted. Throughput: one input transaction per cycle; the
// input stalls only while the output register is full and stalled downstream.
// Reset: rst_n clears the decode state, the output valid flag and both config registers.
// Holds the whole decoder: config registers, decode state and the output register.
// Depends on bpd_pkg and base64_percent_payload_decoder_top_macros.svh.
`include "base64_percent_payload_decoder_top_macros.svh"

module base64_percent_payload_decoder_top
    import bpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  bpd_in_t                in_data,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output bpd_out_t               out_data
);

    // Configuration registers
    logic               mode_reg;
    logic [COUNT_W-1:0] max_out_reg;

    // Decode state
    logic [11:0]        bit_store_reg, bit_store_next;
    logic [3:0]         bit_fill_reg, bit_fill_next;
    logic               pad_seen_reg, pad_seen_next;
    logic [1:0]         esc_pend_reg, esc_pend_next;
    logic [3:0]         esc_high_reg, esc_high_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               fault_reg, fault_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    bpd_out_t           out_data_reg, out_data_next;

    // Step signals
    logic               in_accept;
    logic               res_valid;
    bpd_out_t           res;
    logic               emit_req;
    logic [7:0]         emit_byte;
    logic [3:0]         fill_sum;
    logic [7:0]         store_shifted;
    logic [7:0]         chr;
    sextet_t            sext;
    nibble_t            nib;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign chr       = in_data.in_byte;
    assign sext      = sextet_of(chr);
    assign nib       = nibble_of(chr);
    assign fill_sum  = bit_fill_reg + 4'd6;
    assign store_shifted = 8'({bit_store_reg[5:0], sext.val} >> (fill_sum - 4'd8));

    // Decode one transaction and update the state
    always_comb
    begin
        bit_store_next = bit_store_reg;
        bit_fill_next  = bit_fill_reg;
        pad_seen_next  = pad_seen_reg;
        esc_pend_next  = esc_pend_reg;
        esc_high_next  = esc_high_reg;
        count_next     = count_reg;
        fault_next     = fault_reg;
        res_valid      = 1'b0;
        res.out_byte   = 8'd0;
        res.status     = ST_BYTE;
        res.out_last   = 1'b0;
        emit_req       = 1'b0;
        emit_byte      = 8'd0;

        if (in_accept) begin
            if (in_data.end_of_payload) begin
                // report final status and clear the payload state
                res_valid      = 1'b1;
                res.status     = (fault_reg || esc_pend_reg != ESC_NONE) ? ST_ERR : ST_OK;
                res.out_last   = 1'b1;
                bit_store_next = '0;
                bit_fill_next  = '0;
                pad_seen_next  = 1'b0;
                esc_pend_next  = ESC_NONE;
                esc_high_next  = '0;
                count_next     = '0;
                fault_next     = 1'b0;
            end
            else if (!fault_reg) begin
                if (mode_reg == MODE_BASE64) begin
                    if (is_blank(chr)) begin
                        // skip whitespace
                    end
                    else if (chr == CH_PAD) begin
                        pad_seen_next = 1'b1;
                    end
                    else if (pad_seen_reg || !sext.ok) begin
                        fault_next = 1'b1;
                    end
                    else begin
                        // shift in six bits, drain a byte once eight are pending
                        bit_store_next = {bit_store_reg[5:0], sext.val};
                        if (fill_sum >= 4'd8) begin
                            bit_fill_next = fill_sum - 4'd8;
                            emit_req      = 1'b1;
                            emit_byte     = store_shifted;
                        end
                        else begin
                            bit_fill_next = fill_sum;
                        end
                    end
                end
                else begin
                    if (esc_pend_reg != ESC_NONE) begin
                        if (!nib.ok) begin
                            fault_next = 1'b1;
                        end
                        else if (esc_pend_reg >= ESC_HIGH) begin
                            esc_high_next = nib.val;
                            esc_pend_next = ESC_LOW;
                        end
                        else begin
                            esc_pend_next = ESC_NONE;
                            emit_req      = 1'b1;
                            emit_byte     = {esc_high_reg, nib.val};
                        end
                    end
                    else if (chr == CH_PERCENT) begin
                        esc_pend_next = ESC_HIGH;
                    end
                    else begin
                        emit_req  = 1'b1;
                        emit_byte = chr;
                    end
                end
            end
        end

        // Apply the output limit to an emitted byte
        if (emit_req) begin
            if (max_out_reg != '0 && count_reg >= max_out_reg) begin
                fault_next = 1'b1;
            end
            else begin
                res_valid    = 1'b1;
                res.out_byte = emit_byte;
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end
    end

    // Load the output register on a result, drop it once taken
    always_comb
    begin
        out_data_next = out_data_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_stall) begin
            out_valid_next = out_valid_reg;
        end
        else begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_PERCENT;
            max_out_reg <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DECODE_MODE: mode_reg    <= cfg_data[0];
                CFG_MAX_OUTPUT:  max_out_reg <= cfg_data[COUNT_W-1:0];
                default:         mode_reg    <= mode_reg;
            endcase
        end
    end

    // Decode state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bit_store_reg <= '0;
            bit_fill_reg  <= '0;
            pad_seen_reg  <= 1'b0;
            esc_pend_reg  <= ESC_NONE;
            esc_high_reg  <= '0;
            count_reg     <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            bit_store_reg <= bit_store_next;
            bit_fill_reg  <= bit_fill_next;
            pad_seen_reg  <= pad_seen_next;
            esc_pend_reg  <= esc_pend_next;
            esc_high_reg  <= esc_high_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Assertions
    `BPD_CHECK(a_esc_pend_range, esc_pend_reg != 2'd3)
    `BPD_CHECK(a_fill_even_small, !bit_fill_reg[0] && !bit_fill_reg[3])
    `BPD_CHECK_NEXT(a_end_clears, in_accept && in_data.end_of_payload,
        count_reg == '0 && !fault_reg && esc_pend_reg == ESC_NONE && !pad_seen_reg)
    `BPD_CHECK_NEXT(a_end_reports, in_accept && in_data.end_of_payload,
        out_valid_reg && out_data_reg.out_last && out_data_reg.status != ST_BYTE)

endmodule
